[rtl/core/xialu_pkg.sv]
// ----------------------------------------------------------------------------
// x86 integer ALU package
// Beat types, flag layout, command codes and adjust constants shared by the
// ALU datapath and the top level.
// ----------------------------------------------------------------------------
package xialu_pkg;

  localparam logic [3:0] CMD_ADD = 4'd0;
  localparam logic [3:0] CMD_OR  = 4'd1;
  localparam logic [3:0] CMD_ADC = 4'd2;
  localparam logic [3:0] CMD_SBB = 4'd3;
  localparam logic [3:0] CMD_AND = 4'd4;
  localparam logic [3:0] CMD_SUB = 4'd5;
  localparam logic [3:0] CMD_XOR = 4'd6;
  localparam logic [3:0] CMD_CMP = 4'd7;
  localparam logic [3:0] CMD_INC = 4'd8;
  localparam logic [3:0] CMD_DEC = 4'd9;
  localparam logic [3:0] CMD_DAA = 4'd10;
  localparam logic [3:0] CMD_DAS = 4'd11;
  localparam logic [3:0] CMD_AAA = 4'd12;
  localparam logic [3:0] CMD_AAS = 4'd13;

  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;

  localparam logic [3:0]  BCD_DIGIT_MAX = 4'h9;
  localparam logic [7:0]  BCD_BYTE_MAX  = 8'h99;
  localparam logic [7:0]  DAA_LOW_LIMIT = 8'hf9;
  localparam logic [7:0]  ADJ_LOW       = 8'h06;
  localparam logic [7:0]  ADJ_HIGH      = 8'h60;
  localparam logic [15:0] ASCII_ADJ     = 16'h0106;
  localparam logic [15:0] ASCII_MASK    = 16'hff0f;

  typedef struct packed {
    logic of;
    logic sf;
    logic zf;
    logic af;
    logic pf;
    logic cf;
  } flags_t;

  typedef struct packed {
    logic [3:0]  command;
    logic [1:0]  operand_size;
    logic [31:0] dest_operand;
    logic [31:0] source_operand;
  } in_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        write_back;
    logic        carry_flag;
    logic        parity_flag;
    logic        aux_flag;
    logic        zero_flag;
    logic        sign_flag;
    logic        overflow_flag;
  } out_t;

endpackage

[rtl/core/xialu_exec.sv]
// ----------------------------------------------------------------------------
// x86 integer ALU datapath
// Single-pass arithmetic, logic and BCD adjust logic with flag generation.
// ----------------------------------------------------------------------------
module xialu_exec (
  input  xialu_pkg::in_t    item,
  input  xialu_pkg::flags_t flags_in,
  output xialu_pkg::out_t   result
);
  import xialu_pkg::*;

  logic [31:0] mask;
  logic [31:0] d;
  logic [31:0] s;
  logic [31:0] s_one;
  logic        cin;
  logic [32:0] sum;
  logic [32:0] diff;
  logic [31:0] sum_r;
  logic [31:0] diff_r;
  logic        sum_cf;
  logic [31:0] r;
  logic        wb;
  flags_t      f;

  logic        is_daa;
  logic        is_aaa;
  logic [15:0] ax;
  logic [7:0]  al;
  logic [7:0]  ah;
  logic        low;
  logic        high;
  logic [7:0]  al_step;
  logic        ncf_low;
  logic [7:0]  al1;
  logic [7:0]  al2;
  logic        ncf_dec;
  logic [15:0] ax_ascii;

  function automatic logic size_msb(logic [31:0] v, logic [1:0] sz);
    logic b;
    unique case (sz)
      SIZE_8:  b = v[7];
      SIZE_16: b = v[15];
      default: b = v[31];
    endcase
    return b;
  endfunction

  always_comb begin
    unique case (item.operand_size)
      SIZE_8:  mask = 32'h0000_00ff;
      SIZE_16: mask = 32'h0000_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  assign d      = item.dest_operand & mask;
  assign s      = item.source_operand & mask;
  assign s_one  = ((item.command == CMD_INC) || (item.command == CMD_DEC)) ? 32'd1 : s;
  assign cin    = ((item.command == CMD_ADC) || (item.command == CMD_SBB)) ? flags_in.cf : 1'b0;
  assign sum    = {1'b0, d} + {1'b0, s_one} + {32'd0, cin};
  assign diff   = {1'b0, d} - {1'b0, s_one} - {32'd0, cin};
  assign sum_r  = sum[31:0] & mask;
  assign diff_r = diff[31:0] & mask;

  always_comb begin
    unique case (item.operand_size)
      SIZE_8:  sum_cf = sum[8];
      SIZE_16: sum_cf = sum[16];
      default: sum_cf = sum[32];
    endcase
  end

  assign is_daa  = item.command == CMD_DAA;
  assign is_aaa  = item.command == CMD_AAA;
  assign ax      = item.dest_operand[15:0];
  assign al      = ax[7:0];
  assign ah      = ax[15:8];
  assign low     = (al[3:0] > BCD_DIGIT_MAX) || flags_in.af;
  assign high    = (al > BCD_BYTE_MAX) || flags_in.cf;
  assign al_step = is_daa ? al + ADJ_LOW : al - ADJ_LOW;
  assign ncf_low = low & (flags_in.cf | (is_daa ? (al > DAA_LOW_LIMIT) : (al < ADJ_LOW)));
  assign al1     = low ? al_step : al;
  assign al2     = high ? (is_daa ? al1 + ADJ_HIGH : al1 - ADJ_HIGH) : al1;
  assign ncf_dec = high | (~is_daa & ncf_low);
  assign ax_ascii = (low ? (is_aaa ? ax + ASCII_ADJ : ax - ASCII_ADJ) : ax) & ASCII_MASK;

  always_comb begin
    r  = 32'd0;
    wb = 1'b1;
    f  = flags_in;
    unique case (item.command)
      CMD_ADD, CMD_ADC, CMD_INC: begin
        r    = sum_r;
        f.pf = ~^r[7:0];
        f.zf = r == 32'd0;
        f.sf = size_msb(r, item.operand_size);
        f.of = size_msb(~(d ^ s_one) & (d ^ r), item.operand_size);
        f.af = (d[4] ^ s_one[4] ^ r[4]);
        f.cf = (item.command == CMD_INC) ? flags_in.cf : sum_cf;
      end
      CMD_SBB, CMD_SUB, CMD_CMP, CMD_DEC: begin
        r    = diff_r;
        wb   = item.command != CMD_CMP;
        f.pf = ~^r[7:0];
        f.zf = r == 32'd0;
        f.sf = size_msb(r, item.operand_size);
        f.of = size_msb((d ^ s_one) & (d ^ r), item.operand_size);
        f.af = (d[4] ^ s_one[4] ^ r[4]);
        f.cf = (item.command == CMD_DEC) ? flags_in.cf : diff[32];
      end
      CMD_OR, CMD_AND, CMD_XOR: begin
        if (item.command == CMD_OR) begin
          r = d | s;
        end else if (item.command == CMD_AND) begin
          r = d & s;
        end else begin
          r = d ^ s;
        end
        f.pf = ~^r[7:0];
        f.zf = r == 32'd0;
        f.sf = size_msb(r, item.operand_size);
        f.of = 1'b0;
        f.af = 1'b0;
        f.cf = 1'b0;
      end
      CMD_DAA, CMD_DAS: begin
        r    = {16'd0, ah, al2};
        f.cf = ncf_dec;
        f.af = low;
      end
      CMD_AAA, CMD_AAS: begin
        r    = {16'd0, ax_ascii};
        f.cf = low;
        f.af = low;
      end
      default: begin
        wb = 1'b0;
      end
    endcase
  end

  assign result.result_value  = r;
  assign result.write_back    = wb;
  assign result.carry_flag    = f.cf;
  assign result.parity_flag   = f.pf;
  assign result.aux_flag      = f.af;
  assign result.zero_flag     = f.zf;
  assign result.sign_flag     = f.sf;
  assign result.overflow_flag = f.of;

endmodule

[rtl/core/x86_integer_alu_with_flags_core.sv]
// ----------------------------------------------------------------------------
// x86 integer ALU with status flags
// An accepted input beat is registered in in_data_r, then its result in out_data_r.
// Throughput is one beat per cycle while the output is not stalled; the flag register
// closes its loop through the datapath between the input and result registers.
// Reset clears both valid bits and all six status flags.
// ----------------------------------------------------------------------------
module x86_integer_alu_with_flags_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  xialu_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output xialu_pkg::out_t out_data
);
  import xialu_pkg::*;

  logic   in_valid_r;
  in_t    in_data_r;
  logic   out_valid_r;
  logic   out_valid_nxt;
  out_t   out_data_r;
  flags_t flags_r;
  out_t   exec_result;
  flags_t exec_flags;
  logic   out_load;
  logic   in_load;

  xialu_exec u_exec (
    .item     (in_data_r),
    .flags_in (flags_r),
    .result   (exec_result)
  );

  assign exec_flags.cf = exec_result.carry_flag;
  assign exec_flags.pf = exec_result.parity_flag;
  assign exec_flags.af = exec_result.aux_flag;
  assign exec_flags.zf = exec_result.zero_flag;
  assign exec_flags.sf = exec_result.sign_flag;
  assign exec_flags.of = exec_result.overflow_flag;

  assign out_load      = ~out_valid_r | ~out_stall;
  assign in_load       = ~in_valid_r | out_load;
  assign in_stall      = ~in_load;
  assign out_valid_nxt = out_load ? in_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_load) begin
        in_valid_r <= in_valid;
      end
      if (out_load && in_valid_r) begin
        flags_r <= exec_flags;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && in_valid) begin
      in_data_r <= in_data;
    end
    if (out_load && in_valid_r) begin
      out_data_r <= exec_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
